// File: rtl/fifo_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// FIFO page replacement assertion macros
// Shared concurrent assertion forms for the page replacement checker.
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_MACROS_SVH

// Property checked on every rising edge outside reset
`define FPR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication outside reset
`define FPR_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Widths, register codes, controller states and chain structs.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int ADDR_W      = 32;
  localparam int MAX_FRAMES  = 16;
  localparam int FRAME_W     = $clog2(MAX_FRAMES);
  localparam int FCNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int NUMF_W      = 5;
  localparam int PSIZE_W     = 17;
  localparam int CNT_W       = 32;
  localparam int OUT_FRAME_W = 4;
  localparam int DIV_CNT_W   = $clog2(ADDR_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_TDATA_W  = ((ADDR_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + OUT_FRAME_W + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [NUMF_W-1:0]  NUM_FRAMES_RST = NUMF_W'(4);
  localparam logic [PSIZE_W-1:0] PSIZE_RST      = PSIZE_W'(256);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PSIZE      = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SEARCH,
    S_DONE
  } state_t;

  // Search token that walks the cell row
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] page;
    logic              hit;
    logic [FRAME_W-1:0] frame;
  } token_t;

  // Frame load request broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] idx;
    logic [ADDR_W-1:0]  page;
  } fill_t;

endpackage

// File: rtl/fpr_div.sv
// ----------------------------------------------------------------------------
// FPR divider
// Restoring radix-2 divider: address by page size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fpr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fpr_pkg::ADDR_W-1:0]  dividend,
  input  logic [fpr_pkg::PSIZE_W-1:0] divisor,
  output logic                        done,
  output logic [fpr_pkg::ADDR_W-1:0]  quotient
);
  import fpr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PSIZE_W:0]     rem;
  logic [PSIZE_W:0]     dvs;
  logic [ADDR_W-1:0]    quo;
  logic [PSIZE_W:0]     shifted;
  logic                 take;

  // Trial subtract of the shifted remainder
  assign shifted  = {rem[PSIZE_W-1:0], quo[ADDR_W-1]};
  assign take     = (shifted >= dvs);
  assign quotient = quo;

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: zero divisor counts as one
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= (divisor == '0) ? (PSIZE_W + 1)'(1) : {1'b0, divisor};
    end else if (busy) begin
      rem <= take ? (shifted - dvs) : shifted;
      quo <= {quo[ADDR_W-2:0], take};
    end
  end

endmodule

// File: rtl/fpr_cell.sv
// ----------------------------------------------------------------------------
// FPR frame cell
// Holds one frame's page and valid bit, checks the passing search token.
// ----------------------------------------------------------------------------
module fpr_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fpr_pkg::FRAME_W-1:0] cell_idx,
  input  logic [fpr_pkg::FCNT_W-1:0]  frames_used,
  input  fpr_pkg::fill_t              fill,
  input  fpr_pkg::token_t             tok_in,
  output fpr_pkg::token_t             tok_out
);
  import fpr_pkg::*;

  logic [ADDR_W-1:0] page;
  logic              valid;
  logic              in_use;
  logic              match;
  logic              load;

  assign in_use = ({1'b0, cell_idx} < frames_used);
  assign match  = valid && in_use && !tok_in.hit && (page == tok_in.page);
  assign load   = fill.en && (fill.idx == cell_idx);

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  // Stored page number
  always_ff @(posedge clk) begin
    if (load) begin
      page <= fill.page;
    end
  end

  // Advance the token, mark the first match
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.vld   <= tok_in.vld;
      tok_out.page  <= tok_in.page;
      tok_out.hit   <= tok_in.hit | match;
      tok_out.frame <= match ? cell_idx : tok_in.frame;
    end
  end

endmodule

// File: rtl/fifo_page_replacement.sv
// Each address passes the 32-step divider and then the 16-cell search walk, with
// one item in flight at a time; a new item is taken only once the last commits.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous, active high) clears frame valid bits, victim
// pointer, counters and restores num_frames = 4, psize = 256.
// ----------------------------------------------------------------------------
// FIFO page replacement unit
// Divides each address by the page size, searches resident frames through a
// row of cells and loads missing pages into the FIFO victim frame.
// ----------------------------------------------------------------------------
module fifo_page_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: address[31:0]
  input  logic [fpr_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: fault[0], frame_index[4:1], reference_count[36:5],
  //          fault_count[68:37], zero fill above
  output logic [fpr_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import fpr_pkg::*;

  state_t state, state_next;

  logic [NUMF_W-1:0]  num_frames;
  logic [PSIZE_W-1:0] psize;
  logic [FCNT_W-1:0]  frames_used;
  logic [FRAME_W-1:0] victim;
  logic [FRAME_W-1:0] victim_sel;
  logic [FRAME_W-1:0] victim_next;
  logic [CNT_W-1:0]   refs_seen;
  logic [CNT_W-1:0]   faults_seen;
  logic [CNT_W-1:0]   refs_inc;
  logic [CNT_W-1:0]   faults_inc;
  logic               res_hit;
  logic [FRAME_W-1:0] res_frame;
  logic [FRAME_W-1:0] frame_used;
  logic               accept;
  logic               div_done;
  logic [ADDR_W-1:0]  quotient;
  logic               commit;
  fill_t              fill;
  token_t             tok [MAX_FRAMES+1];

  assign accept = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RST;
      psize      <= PSIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_FRAMES: num_frames <= cfg_data[NUMF_W-1:0];
        REG_PSIZE:      psize      <= cfg_data[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame count to one .. MAX_FRAMES
  always_comb begin
    if (num_frames == '0) begin
      frames_used = FCNT_W'(1);
    end else if (FCNT_W'(num_frames) > FCNT_W'(MAX_FRAMES)) begin
      frames_used = FCNT_W'(MAX_FRAMES);
    end else begin
      frames_used = FCNT_W'(num_frames);
    end
  end

  fpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (s_tdata[ADDR_W-1:0]),
    .divisor  (psize),
    .done     (div_done),
    .quotient (quotient)
  );

  // Launch the search token when the page number is ready
  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = div_done;
    tok[0].page  = quotient;
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    fpr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (FRAME_W'(g)),
      .frames_used (frames_used),
      .fill        (fill),
      .tok_in      (tok[g]),
      .tok_out     (tok[g+1])
    );
  end

  // Capture search result at the end of the row
  always_ff @(posedge clk) begin
    if (tok[MAX_FRAMES].vld) begin
      res_hit   <= tok[MAX_FRAMES].hit;
      res_frame <= tok[MAX_FRAMES].frame;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_SEARCH;
      S_SEARCH: if (tok[MAX_FRAMES].vld) state_next = S_DONE;
      S_DONE:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Controller outputs; take no item while in reset
  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    unique case (state)
      S_IDLE:   s_tready = !rst;
      S_DONE:   commit   = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Victim choice and FIFO pointer advance
  always_comb begin
    victim_sel  = ({1'b0, victim} < frames_used) ? victim : '0;
    victim_next = ((FCNT_W'(victim_sel) + FCNT_W'(1)) >= frames_used) ?
                  '0 : victim_sel + FRAME_W'(1);
    frame_used  = res_hit ? res_frame : victim_sel;
    refs_inc    = (refs_seen == '1) ? refs_seen : refs_seen + CNT_W'(1);
    faults_inc  = (faults_seen == '1) ? faults_seen : faults_seen + CNT_W'(1);
    fill.en     = commit && !res_hit;
    fill.idx    = victim_sel;
    fill.page   = tok[MAX_FRAMES].page;
  end

  // Page number rides in the last token register until commit
  // Update pointer and saturating counters on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      victim      <= '0;
      refs_seen   <= '0;
      faults_seen <= '0;
    end else if (commit) begin
      refs_seen <= refs_inc;
      if (!res_hit) begin
        victim      <= victim_next;
        faults_seen <= faults_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= OUT_TDATA_W'({(res_hit ? faults_seen : faults_inc), refs_inc,
                               OUT_FRAME_W'(frame_used), !res_hit});
    end
  end

endmodule

// File: rtl/fpr_checker.sv
// ----------------------------------------------------------------------------
// FPR port checker
// Watches the top-level ports of the page replacement unit over time.
// ----------------------------------------------------------------------------
`include "fifo_page_replacement_macros.svh"

module fpr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fpr_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import fpr_pkg::*;

  // Hold a stalled result
  `FPR_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

  // One item at a time: no accept right after an accept
  `FPR_ASSERT(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")

  // Faults never outnumber references
  `FPR_ASSERT_IMP(a_fault_le_ref, clk, rst, m_tvalid, (m_tdata[68:37] <= m_tdata[36:5]), "fault count above reference count")

  // A result always counts at least its own reference
  `FPR_ASSERT_IMP(a_ref_nonzero, clk, rst, m_tvalid, (m_tdata[36:5] != '0), "zero reference count")

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (.*);
